>>> rtl/lcfb_pkg.sv
package lcfb_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // byte positions within a full frame: header, payload, crc, repeat count
   localparam int POS_W = 6;
   localparam logic [POS_W-1:0] POS_HDR_FIRST = 6'd0;
   localparam logic [POS_W-1:0] POS_HDR_LAST  = 6'd3;
   localparam logic [POS_W-1:0] POS_PAY_FIRST = 6'd4;
   localparam logic [POS_W-1:0] POS_PAY_LAST  = 6'd35;
   localparam logic [POS_W-1:0] POS_CRC_LO    = 6'd36;
   localparam logic [POS_W-1:0] POS_CRC_HI    = 6'd37;
   localparam logic [POS_W-1:0] POS_REP_LO    = 6'd38;
   localparam logic [POS_W-1:0] POS_REP_HI    = 6'd39;

   localparam int PAY_OFF_W = 5;

   localparam logic [15:0] CRC_POLY = 16'h8408;
   localparam logic [15:0] CRC_INIT = 16'h8408;

   localparam logic [7:0] HDR_WAKE_BYTE   = 8'h40;
   localparam logic [7:0] PAY_START_BYTE  = 8'h85;
   localparam logic [7:0] CMD_PING_BYTE   = 8'h17;
   localparam logic [7:0] CMD_REFRESH_BYTE = 8'h34;
   localparam logic [7:0] FLAG_BYTE       = 8'h01;
   localparam logic [15:0] REFRESH_REPEATS = 16'd1;

   localparam logic CMD_PING    = 1'b0;
   localparam logic CMD_REFRESH = 1'b1;

   typedef struct packed {
      logic        wake_header;
      logic        refresh;
      logic [31:0] label_id;
      logic [15:0] repeats;
   } frame_desc_type;

   function automatic logic [7:0] payload_byte(input frame_desc_type desc,
                                               input logic [PAY_OFF_W-1:0] off);
      logic [7:0] b;
      b = 8'h00;
      case (off)
         5'd0: b = PAY_START_BYTE;
         5'd1: b = desc.label_id[7:0];
         5'd2: b = desc.label_id[15:8];
         5'd3: b = desc.label_id[23:16];
         5'd4: b = desc.label_id[31:24];
         5'd5: b = desc.refresh ? CMD_REFRESH_BYTE : CMD_PING_BYTE;
         5'd6: b = desc.refresh ? 8'h00 : FLAG_BYTE;
         5'd9: b = desc.refresh ? FLAG_BYTE : 8'h00;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // one byte through the reflected crc, lsb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                            input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/lcfb_front.sv
module lcfb_front import lcfb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   output logic           full,
   input  logic           req_cmd,
   input  logic [31:0]    req_label_id,
   input  logic [15:0]    req_repeat_count,
   input  logic           wake_header,
   output logic           desc_valid,
   input  logic           desc_ready,
   output frame_desc_type desc
);

   logic           valid_ff, valid_in;
   frame_desc_type desc_ff, desc_in;
   logic           accept;

   assign full   = valid_ff && !desc_ready;
   assign accept = push && !full;

   always_comb begin
      desc_in             = desc_ff;
      valid_in            = valid_ff;
      if (valid_ff && desc_ready) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in             = 1'b1;
         desc_in.wake_header  = wake_header;
         desc_in.refresh      = (req_cmd == CMD_REFRESH);
         desc_in.label_id     = req_label_id;
         // refresh frames always carry a single repeat
         desc_in.repeats      = (req_cmd == CMD_REFRESH) ? REFRESH_REPEATS
                                                         : req_repeat_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      desc_ff <= desc_in;
   end

   assign desc_valid = valid_ff;
   assign desc       = desc_ff;

endmodule

>>> rtl/lcfb_queue.sv
module lcfb_queue import lcfb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_valid,
   output logic           wr_ready,
   input  frame_desc_type wr_data,
   output logic           rd_valid,
   input  logic           rd_take,
   output frame_desc_type rd_data
);

   frame_desc_type            mem [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_IDX_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                      do_wr, do_rd;

   assign wr_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_take && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/lcfb_back.sv
module lcfb_back import lcfb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           desc_valid,
   output logic           desc_take,
   input  frame_desc_type desc,
   output logic           empty,
   input  logic           pop,
   output logic [7:0]     rsp_frame_byte,
   output logic           rsp_last_byte
);

   logic           active_ff, active_in;
   frame_desc_type cur_ff, cur_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]    crc_ff, crc_in;
   logic           out_valid_ff, out_valid_in;
   logic [7:0]     byte_ff, byte_in;
   logic           last_ff, last_in;
   logic           emit, at_end, load;
   logic [7:0]     cur_byte;
   logic [PAY_OFF_W-1:0] pay_off;

   assign emit    = active_ff && (!out_valid_ff || pop);
   assign at_end  = (pos_ff == POS_REP_HI);
   assign load    = desc_valid && (!active_ff || (emit && at_end));
   assign pay_off = PAY_OFF_W'(pos_ff - POS_PAY_FIRST);

   always_comb begin
      cur_byte = 8'h00;
      if (pos_ff == POS_HDR_LAST) begin
         cur_byte = HDR_WAKE_BYTE;
      end else if (pos_ff >= POS_PAY_FIRST && pos_ff <= POS_PAY_LAST) begin
         cur_byte = payload_byte(cur_ff, pay_off);
      end else begin
         case (pos_ff)
            POS_CRC_LO: cur_byte = crc_ff[7:0];
            POS_CRC_HI: cur_byte = crc_ff[15:8];
            POS_REP_LO: cur_byte = cur_ff.repeats[7:0];
            POS_REP_HI: cur_byte = cur_ff.repeats[15:8];
            default:    cur_byte = 8'h00;
         endcase
      end
   end

   always_comb begin
      active_in    = active_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      out_valid_in = out_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      if (pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (emit) begin
         out_valid_in = 1'b1;
         byte_in      = cur_byte;
         last_in      = at_end;
         pos_in       = pos_ff + 1'b1;
         // crc covers the payload only
         if (pos_ff >= POS_PAY_FIRST && pos_ff <= POS_PAY_LAST) begin
            crc_in = crc_byte(crc_ff, cur_byte);
         end
         if (at_end) begin
            active_in = 1'b0;
         end
      end
      if (load) begin
         active_in = 1'b1;
         cur_in    = desc;
         crc_in    = CRC_INIT;
         pos_in    = desc.wake_header ? POS_HDR_FIRST : POS_PAY_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff  <= cur_in;
      pos_ff  <= pos_in;
      crc_ff  <= crc_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign desc_take      = load;
   assign empty          = !out_valid_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_last_byte  = last_ff;

endmodule

>>> rtl/label_command_frame_builder_core.sv
// Frame builder: each request (ping or refresh, 32-bit label id, repeat count) becomes one
// frame sent one byte per transaction on the result side, the final byte marked by
// rsp_last_byte. A frame is 36 bytes, or 40 when the wake header is enabled; the output
// register delivers one byte per clock while pop is held, and frames follow one another
// with no gap on the result side. Requests are classified and held in a two-entry queue
// ahead of the byte sequencer, so up to three requests can be taken while a frame is
// still going out. The CRC is folded in one byte per cycle while pop is held, as payload
// bytes leave. The header setting is sampled when a request is taken.
module label_command_frame_builder_core import lcfb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_cmd,
   input  logic [31:0] req_label_id,
   input  logic [15:0] req_repeat_count,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last_byte,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   logic           wake_header_ff;
   logic           f_valid, f_ready;
   frame_desc_type f_desc;
   logic           q_valid, q_take;
   frame_desc_type q_desc;

   always_ff @(posedge clock) begin
      if (reset) begin
         wake_header_ff <= 1'b0;
      end else if (csr_write_enable) begin
         wake_header_ff <= csr_write_data;
      end
   end

   lcfb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_cmd          (req_cmd),
      .req_label_id     (req_label_id),
      .req_repeat_count (req_repeat_count),
      .wake_header      (wake_header_ff),
      .desc_valid       (f_valid),
      .desc_ready       (f_ready),
      .desc             (f_desc)
   );

   lcfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (f_valid),
      .wr_ready (f_ready),
      .wr_data  (f_desc),
      .rd_valid (q_valid),
      .rd_take  (q_take),
      .rd_data  (q_desc)
   );

   lcfb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .desc_valid     (q_valid),
      .desc_take      (q_take),
      .desc           (q_desc),
      .empty          (empty),
      .pop            (pop),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule

>>> tb/sv/label_command_frame_builder_core_tb.sv
`timescale 1ns / 100ps

module label_command_frame_builder_core_tb import lcfb_pkg::*; ();

   logic        clock = 1'b0;
   logic        reset;
   logic        push;
   logic        full;
   logic        req_cmd;
   logic [31:0] req_label_id;
   logic [15:0] req_repeat_count;
   logic        empty;
   logic        pop;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_last_byte;
   logic        csr_write_enable;
   logic        csr_write_data;

   logic        wake_setting;

   typedef struct {
      logic [7:0] value;
      logic       is_last;
   } frame_byte_type;

   class frame_checker;
      frame_byte_type frame_bytes_due[$];
      int mismatches;
      int bytes_checked;
      int pings_taken;
      int refreshes_taken;
      int wake_frames;

      function new();
         mismatches = 0;
         bytes_checked = 0;
         pings_taken = 0;
         refreshes_taken = 0;
         wake_frames = 0;
      endfunction

      task report(string what);
         $display("ERROR at %0t: %s", $time, what);
         mismatches++;
      endtask

      // builds the whole frame for one accepted request and queues its bytes
      function void take_request(logic cmd, logic [31:0] label_id, logic [15:0] repeats,
                                 logic wake);
         logic [7:0]  payload [32];
         logic [7:0]  frame [40];
         logic [15:0] crc;
         logic [15:0] count;
         int          n;
         frame_byte_type fb;
         for (int i = 0; i < 32; i++) begin
            payload[i] = 8'h00;
         end
         payload[0] = PAY_START_BYTE;
         payload[1] = label_id[7:0];
         payload[2] = label_id[15:8];
         payload[3] = label_id[23:16];
         payload[4] = label_id[31:24];
         if (cmd == CMD_REFRESH) begin
            payload[5] = CMD_REFRESH_BYTE;
            payload[9] = FLAG_BYTE;
            count = REFRESH_REPEATS;
            refreshes_taken++;
         end else begin
            payload[5] = CMD_PING_BYTE;
            payload[6] = FLAG_BYTE;
            count = repeats;
            pings_taken++;
         end
         // reflected crc over the payload only
         crc = CRC_INIT;
         for (int i = 0; i < 32; i++) begin
            crc = crc ^ {8'h00, payload[i]};
            for (int b = 0; b < 8; b++) begin
               crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
         end
         n = 0;
         if (wake) begin
            frame[0] = 8'h00;
            frame[1] = 8'h00;
            frame[2] = 8'h00;
            frame[3] = HDR_WAKE_BYTE;
            n = 4;
            wake_frames++;
         end
         for (int i = 0; i < 32; i++) begin
            frame[n] = payload[i];
            n++;
         end
         frame[n]   = crc[7:0];
         frame[n+1] = crc[15:8];
         frame[n+2] = count[7:0];
         frame[n+3] = count[15:8];
         n = n + 4;
         for (int i = 0; i < n; i++) begin
            fb.value = frame[i];
            fb.is_last = (i == n - 1);
            frame_bytes_due.push_back(fb);
         end
      endfunction

      task check_byte(logic [7:0] value, logic is_last);
         frame_byte_type want;
         if (frame_bytes_due.size() == 0) begin
            report($sformatf("byte %02h last %0b with no frame pending", value, is_last));
            return;
         end
         want = frame_bytes_due.pop_front();
         if (value !== want.value) begin
            report($sformatf("byte %0d: frame_byte %02h, expected %02h",
                             bytes_checked, value, want.value));
         end
         if (is_last !== want.is_last) begin
            report($sformatf("byte %0d: last_byte %0b, expected %0b",
                             bytes_checked, is_last, want.is_last));
         end
         bytes_checked++;
      endtask
   endclass

   frame_checker chk = new();

   label_command_frame_builder_core dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_cmd          (req_cmd),
      .req_label_id     (req_label_id),
      .req_repeat_count (req_repeat_count),
      .empty            (empty),
      .pop              (pop),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_last_byte    (rsp_last_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // leaves push high after the transaction so a back-to-back request needs no toggle
   task automatic offer_request(input logic cmd, input logic [31:0] label_id,
                                input logic [15:0] repeats);
      push <= 1'b1;
      req_cmd <= cmd;
      req_label_id <= label_id;
      req_repeat_count <= repeats;
      do @(posedge clock); while (full);
      chk.take_request(cmd, label_id, repeats, wake_setting);
   endtask

   task automatic pause_requests(input int cycles);
      push <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic write_wake_header(input logic value);
      pause_requests(1);
      while (chk.frame_bytes_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      wake_setting = value;
   endtask

   task automatic run_directed();
      logic [31:0] ids [5];
      logic [15:0] ping_reps [5];
      logic [15:0] refresh_reps [5];
      ids = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'hA5A5_5A5A, 32'h8000_0001};
      ping_reps = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h0001};
      refresh_reps = '{16'hFFFF, 16'h0000, 16'h1234, 16'h0001, 16'h8000};
      for (int i = 0; i < 5; i++) begin
         offer_request(CMD_PING, ids[i], ping_reps[i]);
         offer_request(CMD_REFRESH, ids[i], refresh_reps[i]);
         if (i % 2 == 1) begin
            pause_requests(2);
         end
      end
   endtask

   task automatic run_random(input int count);
      int          r;
      int          steady_left;
      logic [31:0] label_id;
      logic [15:0] repeats;
      steady_left = 0;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         label_id = (r < 5) ? 32'h0 : (r < 10) ? 32'hFFFF_FFFF : 32'($urandom);
         r = $urandom_range(0, 99);
         repeats = (r < 10) ? 16'h0 : (r < 20) ? 16'hFFFF : 16'($urandom_range(0, 65535));
         offer_request($urandom_range(0, 1) ? CMD_REFRESH : CMD_PING, label_id, repeats);
         r = $urandom_range(0, 99);
         if (steady_left > 0) begin
            steady_left--;
         end else if (r < 5) begin
            steady_left = $urandom_range(4, 10);
         end else if (r < 55) begin
            // back to back
         end else if (r < 90) begin
            pause_requests($urandom_range(1, 3));
         end else begin
            pause_requests($urandom_range(10, 60));
         end
      end
   endtask

   // result side: random stalls, calm stretches, and one long hold to back up the input
   initial begin : result_side
      int hold_left;
      int calm_left;
      int r;
      bit pressure_done;
      hold_left = 0;
      calm_left = 0;
      pressure_done = 0;
      pop <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (pop && !empty) begin
            chk.check_byte(rsp_frame_byte, rsp_last_byte);
         end
         if (!pressure_done && chk.bytes_checked >= 1200) begin
            pressure_done = 1;
            hold_left = 500;
            calm_left = 0;
         end else if (hold_left == 0 && calm_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
               calm_left = $urandom_range(40, 200);
            end else if (r < 15) begin
               hold_left = $urandom_range(1, 3);
            end else if (r < 17) begin
               hold_left = $urandom_range(15, 50);
            end
         end
         if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
         end else begin
            pop <= 1'b1;
            if (calm_left > 0) calm_left--;
         end
         @(posedge clock);
      end
   end

   initial begin : request_side
      reset <= 1'b1;
      push <= 1'b0;
      req_cmd <= CMD_PING;
      req_label_id <= 32'h0;
      req_repeat_count <= 16'h0;
      csr_write_enable <= 1'b0;
      csr_write_data <= 1'b0;
      wake_setting = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      write_wake_header(1'b1);
      run_directed();
      write_wake_header(1'b0);
      run_random(30);
      write_wake_header(1'b1);
      run_random(30);
      write_wake_header(1'($urandom_range(0, 1)));
      run_random(20);
      write_wake_header(1'($urandom_range(0, 1)));
      run_random(20);

      pause_requests(1);
      while (chk.frame_bytes_due.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (chk.frame_bytes_due.size() != 0) begin
         chk.report($sformatf("%0d frame bytes never arrived", chk.frame_bytes_due.size()));
      end

      $display("run covered %0d ping and %0d refresh frames, %0d with the wake header",
               chk.pings_taken, chk.refreshes_taken, chk.wake_frames);
      $display("%0d frame bytes checked, %0d errors", chk.bytes_checked, chk.mismatches);
      if (chk.mismatches == 0) begin
         $display("label_command_frame_builder_core: match");
      end else begin
         $display("label_command_frame_builder_core: mismatch");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("timeout waiting for the frame builder");
      $display("label_command_frame_builder_core: mismatch");
      $finish;
   end

endmodule
